@@ rtl/uvs_pkg.sv @@
// Shared types, constants and lookup tables of the UV sphere vertex generator.
package uvs_pkg;

   localparam int DETAIL_MAX      = 256;
   localparam int FRAC_BITS       = 16;
   localparam int D_W             = $clog2(DETAIL_MAX + 1);
   localparam int H_W             = $clog2(DETAIL_MAX / 2 + 1);
   localparam int K_W             = H_W;
   localparam int BAND_W          = 7;
   localparam int COL_W           = 9;
   localparam int IDX_W           = 17;
   localparam int TEX_W           = FRAC_BITS + 1;
   localparam int NUM_W           = FRAC_BITS + D_W;
   localparam int RECIP_SH        = NUM_W + D_W - 1;
   localparam int RECIP_W         = RECIP_SH - 1;
   localparam int ANG_W           = 32;
   localparam int CW              = 34;
   localparam int CORDIC_STEPS    = 30;
   localparam int ITERS_PER_STAGE = 3;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / ITERS_PER_STAGE;
   localparam int CORDIC_K        = 652032874;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
   };

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_CFG = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DETAIL      = 3'd0,
      CSR_RADIUS      = 3'd1,
      CSR_OFFSET_X    = 3'd2,
      CSR_OFFSET_Y    = 3'd3,
      CSR_OFFSET_Z    = 3'd4,
      CSR_UPPER_FIRST = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [8:0]         detail;
      logic [30:0]        radius;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic               upper_first;
   } cfg_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] idx;
      logic [K_W-1:0]   k;
      logic [COL_W-1:0] col;
      logic             last;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } job_type;

   typedef struct packed {
      status_type         status;
      logic [IDX_W-1:0]   vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
      logic               last;
   } vertex_type;

   typedef logic [RECIP_W-1:0] recip_tab_type [DETAIL_MAX/2+1];
   typedef logic [31:0]        quot_tab_type  [DETAIL_MAX/2+1];
   typedef logic [D_W-1:0]     rem_tab_type   [DETAIL_MAX/2+1];

   // shift-subtract divide, only used to build the tables below
   function automatic longint unsigned long_div(input longint unsigned n,
                                                input longint unsigned dv,
                                                input bit want_rem);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         q = q << 1;
         if (r >= dv) begin
            r = r - dv;
            q = q | 64'd1;
         end
      end
      return want_rem ? r : q;
   endfunction

   // ceil(2^RECIP_SH / d), indexed by d/2
   function automatic recip_tab_type make_recip();
      recip_tab_type    t;
      longint unsigned  dd;
      for (int h = 0; h <= DETAIL_MAX / 2; h++) begin
         dd   = longint'(2 * h);
         t[h] = (h == 0) ? '0 :
                RECIP_W'(long_div((64'd1 << RECIP_SH) + dd - 64'd1, dd, 1'b0));
      end
      return t;
   endfunction

   // floor(2^32 / d)
   function automatic quot_tab_type make_quot();
      quot_tab_type    t;
      longint unsigned dd;
      for (int h = 0; h <= DETAIL_MAX / 2; h++) begin
         dd   = longint'(2 * h);
         t[h] = (h == 0) ? '0 : 32'(long_div(64'd1 << 32, dd, 1'b0));
      end
      return t;
   endfunction

   // 2^32 mod d
   function automatic rem_tab_type make_rem();
      rem_tab_type     t;
      longint unsigned dd;
      for (int h = 0; h <= DETAIL_MAX / 2; h++) begin
         dd   = longint'(2 * h);
         t[h] = (h == 0) ? '0 : D_W'(long_div(64'd1 << 32, dd, 1'b1));
      end
      return t;
   endfunction

   localparam recip_tab_type RECIP_TAB = make_recip();
   localparam quot_tab_type  QUOT_TAB  = make_quot();
   localparam rem_tab_type   REM_TAB   = make_rem();

   // detail rounded up to even
   function automatic logic [D_W:0] even_detail(input cfg_type c);
      return (D_W+1)'(c.detail) + (D_W+1)'(c.detail[0]);
   endfunction

endpackage

@@ rtl/uvs_if.sv @@
// Channel interfaces: request, vertex response and register write.
interface uvs_req_if;
   import uvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [BAND_W-1:0]   band;
   logic [COL_W-1:0]    column;
   modport source (output valid, band, column, input ready);
   modport sink   (input valid, band, column, output ready);
endinterface

interface uvs_rsp_if;
   import uvs_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [IDX_W-1:0]    vertex_index;
   logic signed [31:0]  pos_x;
   logic signed [31:0]  pos_y;
   logic signed [31:0]  pos_z;
   logic signed [15:0]  norm_x;
   logic signed [15:0]  norm_y;
   logic signed [15:0]  norm_z;
   logic [TEX_W-1:0]    tex_u;
   logic [TEX_W-1:0]    tex_v;
   logic                last;
   modport source (output valid, status, vertex_index, pos_x, pos_y, pos_z,
                   norm_x, norm_y, norm_z, tex_u, tex_v, last, input ready);
   modport sink   (input valid, status, vertex_index, pos_x, pos_y, pos_z,
                   norm_x, norm_y, norm_z, tex_u, tex_v, last, output ready);
endinterface

interface uvs_csr_if;
   import uvs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/uvs_split.sv @@
// Request checker and splitter: one request becomes one or two vertex jobs.
module uvs_split (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  uvs_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [uvs_pkg::BAND_W-1:0] in_band,
   input  logic [uvs_pkg::COL_W-1:0] in_col,
   output logic                      out_valid,
   output uvs_pkg::job_type          out_job
);
   import uvs_pkg::*;

   logic               hold_v_ff, hold_v_in;
   logic               phase_ff, phase_in;
   status_type         status_ff, status_in;
   logic [BAND_W-1:0]  band_ff;
   logic [COL_W-1:0]   col_ff;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [D_W:0]       d;
   logic               bad, range_err, job_last, accept, up;
   logic [IDX_W-1:0]   inner;

   assign d         = even_detail(cfg);
   assign bad       = (cfg.detail < 9'd4) || (cfg.radius == '0) ||
                      (d > (D_W+1)'(DETAIL_MAX));
   assign range_err = ((D_W+1)'(in_band) >= (d >> 1)) || ((D_W+1)'(in_col) > d);
   assign inner     = IDX_W'(IDX_W'(in_band) * IDX_W'(d + (D_W+1)'(1))) + IDX_W'(in_col);
   assign status_in = bad ? ST_BAD_CFG : (range_err ? ST_RANGE : ST_OK);
   assign base_in   = {inner[IDX_W-2:0], 1'b0};

   assign job_last = phase_ff || (status_ff != ST_OK);
   assign in_ready = !hold_v_ff || (en && job_last);
   assign accept   = in_valid && in_ready;

   always_comb begin
      hold_v_in = hold_v_ff;
      phase_in  = phase_ff;
      if (en && hold_v_ff) begin
         if (job_last) hold_v_in = 1'b0;
         else phase_in = 1'b1;
      end
      if (accept) begin
         hold_v_in = 1'b1;
         phase_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         band_ff   <= in_band;
         col_ff    <= in_col;
         base_ff   <= base_in;
      end
   end

   // second job of a pair takes the other latitude
   assign up        = phase_ff ^ cfg.upper_first;
   assign out_valid = hold_v_ff;
   always_comb begin
      out_job        = '0;
      out_job.status = status_ff;
      out_job.idx    = base_ff | IDX_W'(phase_ff);
      out_job.k      = K_W'(band_ff) + K_W'(up);
      out_job.col    = col_ff;
      out_job.last   = job_last;
   end

endmodule

@@ rtl/uvs_angle.sv @@
// Binary angles and texture coordinates by reciprocal multiplication, two stages.
module uvs_angle (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  uvs_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   input  uvs_pkg::job_type          in_job,
   output logic                      out_valid,
   output uvs_pkg::job_type          out_job,
   output logic [uvs_pkg::ANG_W-1:0] out_lat,
   output logic [uvs_pkg::ANG_W-1:0] out_col
);
   import uvs_pkg::*;

   localparam int LO_W   = K_W + D_W + 1;
   localparam int PROD_W = NUM_W + RECIP_W;
   localparam int T_W    = LO_W + RECIP_W;

   logic [D_W:0]         d;
   logic [H_W-1:0]       h;
   logic [D_W-1:0]       half_d;
   logic [RECIP_W-1:0]   recip;
   logic [31:0]          quot;
   logic [D_W-1:0]       rem;
   logic [COL_W-1:0]     rc;

   logic [K_W+31:0]      lat_hi_p;
   logic [COL_W+31:0]    col_hi_p;
   logic [LO_W-1:0]      lat_lo, col_lo;
   logic [NUM_W-1:0]     num_u, num_v;
   logic [PROD_W-1:0]    tex_u_p, tex_v_p;
   job_type              a_job_in;

   logic                 a_v_ff;
   job_type              a_job_ff;
   logic [31:0]          a_lat_hi_ff, a_col_hi_ff;
   logic [LO_W-1:0]      a_lat_lo_ff, a_col_lo_ff;

   logic [T_W-1:0]       lat_t_p, col_t_p;
   logic [ANG_W-1:0]     lat_in, col_in;

   logic                 b_v_ff;
   job_type              b_job_ff;
   logic [ANG_W-1:0]     b_lat_ff, b_col_ff;

   assign d      = even_detail(cfg);
   assign h      = d[H_W:1];
   assign half_d = d[D_W:1];
   assign recip  = RECIP_TAB[h];
   assign quot   = QUOT_TAB[h];
   assign rem    = REM_TAB[h];

   // column d is a full turn, same as column zero
   assign rc = ({1'b0, in_job.col} == d) ? '0 : in_job.col;

   // k*2^32/d = k*floor(2^32/d) + (k*(2^32 mod d) + d/2)/d, mod 2^32
   assign lat_hi_p = (K_W+32)'(in_job.k) * (K_W+32)'(quot);
   assign col_hi_p = (COL_W+32)'(rc) * (COL_W+32)'(quot);
   assign lat_lo   = LO_W'(LO_W'(in_job.k) * LO_W'(rem)) + LO_W'(half_d);
   assign col_lo   = LO_W'(LO_W'(rc) * LO_W'(rem)) + LO_W'(half_d);

   assign num_u   = {in_job.col, {FRAC_BITS{1'b0}}} + NUM_W'(half_d);
   assign num_v   = {in_job.k, 1'b0, {FRAC_BITS{1'b0}}} + NUM_W'(half_d);
   assign tex_u_p = PROD_W'(num_u) * PROD_W'(recip);
   assign tex_v_p = PROD_W'(num_v) * PROD_W'(recip);

   always_comb begin
      a_job_in       = in_job;
      a_job_in.tex_u = tex_u_p[RECIP_SH +: TEX_W];
      a_job_in.tex_v = tex_v_p[RECIP_SH +: TEX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_job_ff    <= a_job_in;
         a_lat_hi_ff <= lat_hi_p[31:0];
         a_col_hi_ff <= col_hi_p[31:0];
         a_lat_lo_ff <= lat_lo;
         a_col_lo_ff <= col_lo;
      end
   end

   assign lat_t_p = T_W'(a_lat_lo_ff) * T_W'(recip);
   assign col_t_p = T_W'(a_col_lo_ff) * T_W'(recip);
   // latitude starts a quarter turn below the equator
   assign lat_in  = a_lat_hi_ff + ANG_W'(lat_t_p[RECIP_SH +: D_W]) - 32'h4000_0000;
   assign col_in  = a_col_hi_ff + ANG_W'(col_t_p[RECIP_SH +: D_W]);

   always_ff @(posedge clock) begin
      if (en) begin
         b_job_ff <= a_job_ff;
         b_lat_ff <= lat_in;
         b_col_ff <= col_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_job   = b_job_ff;
   assign out_lat   = b_lat_ff;
   assign out_col   = b_col_ff;

endmodule

@@ rtl/uvs_cordic.sv @@
// Two-lane pipelined CORDIC: cosine and sine of latitude and longitude in Q2.30.
module uvs_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  uvs_pkg::job_type          in_job,
   input  logic [uvs_pkg::ANG_W-1:0] in_lat,
   input  logic [uvs_pkg::ANG_W-1:0] in_col,
   output logic                      out_valid,
   output uvs_pkg::job_type          out_job,
   output logic signed [31:0]        out_cl,
   output logic signed [31:0]        out_sl,
   output logic signed [31:0]        out_co,
   output logic signed [31:0]        out_so
);
   import uvs_pkg::*;

   localparam int NS = CORDIC_STAGES + 1;

   logic [ANG_W-1:0]     ang [2];
   logic [1:0]           q_in [2];
   logic [ANG_W-1:0]     zr [2];

   logic                 v_ff   [NS];
   job_type              job_ff [NS];
   logic [1:0]           q_ff   [NS][2];
   logic signed [CW-1:0] x_ff   [NS][2];
   logic signed [CW-1:0] y_ff   [NS][2];
   logic signed [CW-1:0] z_ff   [NS][2];

   logic                 f_v_ff;
   job_type              f_job_ff;
   logic signed [31:0]   c_ff [2];
   logic signed [31:0]   s_ff [2];
   logic signed [CW-1:0] c_in [2];
   logic signed [CW-1:0] s_in [2];

   assign ang[0] = in_lat;
   assign ang[1] = in_col;

   // fold into the quadrant around zero
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_in[l] = 2'((ang[l] + 32'h2000_0000) >> 30);
         zr[l]   = ang[l] - {q_in[l], 30'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff[0] <= in_job;
         for (int l = 0; l < 2; l++) begin
            q_ff[0][l] <= q_in[l];
            x_ff[0][l] <= CW'(CORDIC_K);
            y_ff[0][l] <= '0;
            z_ff[0][l] <= CW'($signed(zr[l]));
         end
      end
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      logic signed [CW-1:0] xn [2];
      logic signed [CW-1:0] yn [2];
      logic signed [CW-1:0] zn [2];

      always_comb begin
         logic signed [CW-1:0] xt, yt, zt, dx, dy, at;
         for (int l = 0; l < 2; l++) begin
            xt = x_ff[s][l];
            yt = y_ff[s][l];
            zt = z_ff[s][l];
            for (int j = 0; j < ITERS_PER_STAGE; j++) begin
               dx = yt >>> (s * ITERS_PER_STAGE + j);
               dy = xt >>> (s * ITERS_PER_STAGE + j);
               at = $signed(CW'(ATAN_TAB[s * ITERS_PER_STAGE + j]));
               if (zt >= 0) begin
                  xt = xt - dx;
                  yt = yt + dy;
                  zt = zt - at;
               end else begin
                  xt = xt + dx;
                  yt = yt - dy;
                  zt = zt + at;
               end
            end
            xn[l] = xt;
            yn[l] = yt;
            zn[l] = zt;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            job_ff[s+1] <= job_ff[s];
            q_ff[s+1]   <= q_ff[s];
            x_ff[s+1]   <= xn;
            y_ff[s+1]   <= yn;
            z_ff[s+1]   <= zn;
         end
      end
   end

   // rotate back by the folded quadrant
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         case (q_ff[CORDIC_STAGES][l])
            2'd0: begin
               c_in[l] = x_ff[CORDIC_STAGES][l];
               s_in[l] = y_ff[CORDIC_STAGES][l];
            end
            2'd1: begin
               c_in[l] = -y_ff[CORDIC_STAGES][l];
               s_in[l] = x_ff[CORDIC_STAGES][l];
            end
            2'd2: begin
               c_in[l] = -x_ff[CORDIC_STAGES][l];
               s_in[l] = -y_ff[CORDIC_STAGES][l];
            end
            default: begin
               c_in[l] = y_ff[CORDIC_STAGES][l];
               s_in[l] = -x_ff[CORDIC_STAGES][l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= v_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_job_ff <= job_ff[CORDIC_STAGES];
         for (int l = 0; l < 2; l++) begin
            c_ff[l] <= 32'(c_in[l]);
            s_ff[l] <= 32'(s_in[l]);
         end
      end
   end

   assign out_valid = f_v_ff;
   assign out_job   = f_job_ff;
   assign out_cl    = c_ff[0];
   assign out_sl    = s_ff[0];
   assign out_co    = c_ff[1];
   assign out_so    = s_ff[1];

endmodule

@@ rtl/uvs_vertex.sv @@
// Direction, normal and position of a vertex, ending in the output register.
module uvs_vertex (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  uvs_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  uvs_pkg::job_type   in_job,
   input  logic signed [31:0] in_cl,
   input  logic signed [31:0] in_sl,
   input  logic signed [31:0] in_co,
   input  logic signed [31:0] in_so,
   output logic               out_valid,
   output uvs_pkg::vertex_type out_vtx
);
   import uvs_pkg::*;

   function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
      logic signed [17:0] r;
      r = 18'((33'(v) + 33'sd16384) >>> 15);
      if (r > 18'sd32767) return 16'sh7FFF;
      else if (r < -18'sd32768) return 16'sh8000;
      else return 16'(r);
   endfunction

   function automatic logic signed [31:0] place(input logic signed [31:0] off,
                                               input logic signed [63:0] p);
      logic signed [33:0] s;
      s = 34'(off) + 34'((p + 64'sd536870912) >>> 30);
      if (s > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else if (s < -34'sh0_8000_0000) return 32'sh8000_0000;
      else return 32'(s);
   endfunction

   logic signed [63:0] pc, ps;
   logic signed [31:0] rad;

   logic               d_v_ff, e_v_ff, f_v_ff;
   job_type            d_job_ff, e_job_ff;
   logic signed [31:0] e_ff [3];
   logic signed [63:0] p_ff [3];
   logic signed [15:0] n_ff [3];
   vertex_type         f_vtx_ff, f_vtx_in;

   assign pc  = 64'(in_cl) * 64'(in_co);
   assign ps  = 64'(in_cl) * 64'(in_so);
   assign rad = $signed({1'b0, cfg.radius});

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= in_valid;
         e_v_ff <= d_v_ff;
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_job_ff <= in_job;
         e_ff[0]  <= 32'((pc + 64'sd536870912) >>> 30);
         e_ff[1]  <= in_sl;
         e_ff[2]  <= 32'((ps + 64'sd536870912) >>> 30);
         e_job_ff <= d_job_ff;
         for (int n = 0; n < 3; n++) begin
            p_ff[n] <= 64'(rad) * 64'(e_ff[n]);
            n_ff[n] <= to_q15(e_ff[n]);
         end
         f_vtx_ff <= f_vtx_in;
      end
   end

   always_comb begin
      f_vtx_in = '0;
      f_vtx_in.status = e_job_ff.status;
      f_vtx_in.last   = e_job_ff.last;
      if (e_job_ff.status == ST_OK) begin
         f_vtx_in.vertex_index = e_job_ff.idx;
         f_vtx_in.pos_x        = place(cfg.offset_x, p_ff[0]);
         f_vtx_in.pos_y        = place(cfg.offset_y, p_ff[1]);
         f_vtx_in.pos_z        = place(cfg.offset_z, p_ff[2]);
         f_vtx_in.norm_x       = n_ff[0];
         f_vtx_in.norm_y       = n_ff[1];
         f_vtx_in.norm_z       = n_ff[2];
         f_vtx_in.tex_u        = e_job_ff.tex_u;
         f_vtx_in.tex_v        = e_job_ff.tex_v;
      end
   end

   assign out_valid = f_v_ff;
   assign out_vtx   = f_vtx_ff;

endmodule

@@ rtl/uv_sphere_vertex_generator.sv @@
// Top level: registers, request splitter, angle, CORDIC and vertex pipelines.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   band, column
//   rsp_ch   out  valid/ready   status, vertex_index, pos, norm, tex, last
//   csr_ch   in   valid/ready   index, data (ready always high)
//
// A request yields two vertices that share one result port, or a single error
// result. Each vertex passes through the hold register, 2 angle stages, CORDIC
// input, 10 stages of three CORDIC steps each, CORDIC output and 3 vertex stages,
// the second vertex right behind the first.
// Synchronous reset clears valid bits and restores register defaults.
// The whole pipeline advances whenever the output register is empty or taken;
// a stalled result holds and nothing inside moves, but an empty hold register may take a request.
module uv_sphere_vertex_generator (
   input  logic clock,
   input  logic reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch,
   uvs_csr_if.sink   csr_ch
);
   import uvs_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               en;
   logic               sp_v, an_v, co_v, vx_v;
   job_type            sp_job, an_job, co_job;
   logic [ANG_W-1:0]   an_lat, an_col;
   logic signed [31:0] cl, sl, co, so;
   vertex_type         vtx;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DETAIL:      cfg_in.detail      = csr_ch.data[8:0];
            CSR_RADIUS:      cfg_in.radius      = csr_ch.data[30:0];
            CSR_OFFSET_X:    cfg_in.offset_x    = csr_ch.data;
            CSR_OFFSET_Y:    cfg_in.offset_y    = csr_ch.data;
            CSR_OFFSET_Z:    cfg_in.offset_z    = csr_ch.data;
            CSR_UPPER_FIRST: cfg_in.upper_first = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detail      <= 9'd16;
         cfg_ff.radius      <= 31'd65536;
         cfg_ff.offset_x    <= '0;
         cfg_ff.offset_y    <= '0;
         cfg_ff.offset_z    <= '0;
         cfg_ff.upper_first <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en = !vx_v || rsp_ch.ready;

   uvs_split u_split (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_band   (req_ch.band),
      .in_col    (req_ch.column),
      .out_valid (sp_v),
      .out_job   (sp_job)
   );

   uvs_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (sp_v),
      .in_job    (sp_job),
      .out_valid (an_v),
      .out_job   (an_job),
      .out_lat   (an_lat),
      .out_col   (an_col)
   );

   uvs_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (an_v),
      .in_job    (an_job),
      .in_lat    (an_lat),
      .in_col    (an_col),
      .out_valid (co_v),
      .out_job   (co_job),
      .out_cl    (cl),
      .out_sl    (sl),
      .out_co    (co),
      .out_so    (so)
   );

   uvs_vertex u_vertex (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (co_v),
      .in_job    (co_job),
      .in_cl     (cl),
      .in_sl     (sl),
      .in_co     (co),
      .in_so     (so),
      .out_valid (vx_v),
      .out_vtx   (vtx)
   );

   assign rsp_ch.valid        = vx_v;
   assign rsp_ch.status       = vtx.status;
   assign rsp_ch.vertex_index = vtx.vertex_index;
   assign rsp_ch.pos_x        = vtx.pos_x;
   assign rsp_ch.pos_y        = vtx.pos_y;
   assign rsp_ch.pos_z        = vtx.pos_z;
   assign rsp_ch.norm_x       = vtx.norm_x;
   assign rsp_ch.norm_y       = vtx.norm_y;
   assign rsp_ch.norm_z       = vtx.norm_z;
   assign rsp_ch.tex_u        = vtx.tex_u;
   assign rsp_ch.tex_v        = vtx.tex_v;
   assign rsp_ch.last         = vtx.last;

endmodule
